/* src/pce_pkg.sv */
// Shared types and constants of the prefix-code byte encoder.
// No dependencies; every other file imports this package.
package pce_pkg;

	localparam int SYM_W        = 8;
	localparam int TABLE_SIZE   = 256;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 3;
	localparam int WORD_W       = CODE_W + BYTE_W;
	localparam int REM_W        = 6;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_W      = $clog2(Q_DEPTH);
	localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	// one queued job for the packer; code is left-aligned
	typedef struct packed {
		logic              fin;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} job_t;

endpackage

/* src/pce_if.sv */
// Handshake channels of the prefix-code byte encoder: input items and result items.
// Depends on pce_pkg for field widths.
interface pce_in_if;
	import pce_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [SYM_W-1:0]    symbol;
	logic [CODE_W-1:0]   code_bits;
	logic [LEN_W-1:0]    code_length;

	modport source (output valid, func, symbol, code_bits, code_length, input ready);
	modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface pce_out_if;
	import pce_pkg::*;
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_of_run;
	logic                end_of_message;

	modport source (output valid, out_byte, last_of_run, end_of_message, input ready);
	modport sink   (input valid, out_byte, last_of_run, end_of_message, output ready);
endinterface

/* src/pce_front.sv */
// Front end: accepts items, holds the code table, looks up encode symbols.
// Depends on pce_pkg and pce_if; feeds jobs to pce_queue.
module pce_front
	import pce_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pce_in_if.sink        enc_in,
	input  logic [Q_CNT_W-1:0] q_cnt,
	output logic          push,
	output job_t          push_job
);

	localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

	logic [CODE_W-1:0]     code_mem [TABLE_SIZE];
	logic [LEN_W-1:0]      len_mem  [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] len_vld_q;

	logic                  valid_s1;
	logic                  fin_s1;
	logic                  vld_s1;
	logic [CODE_W-1:0]     code_s1;
	logic [LEN_W-1:0]      len_s1;

	logic                  accept;
	logic                  is_load;
	logic                  is_job;
	logic [LEN_W-1:0]      len_sat;
	logic [CODE_W:0]       mask_w;
	logic [CODE_W-1:0]     code_masked;
	logic [LEN_W-1:0]      len_eff;
	logic [Q_CNT_W:0]      occ;

	assign occ          = {1'b0, q_cnt} + (Q_CNT_W+1)'(valid_s1);
	assign enc_in.ready = (occ < (Q_CNT_W+1)'(Q_DEPTH));
	assign accept       = enc_in.valid && enc_in.ready;

	always_comb begin
		is_load = 1'b0;
		is_job  = 1'b0;
		unique case (func_t'(enc_in.func))
			FUNC_LOAD:   is_load = 1'b1;
			FUNC_ENCODE: is_job  = 1'b1;
			FUNC_FINISH: is_job  = 1'b1;
			default: begin
				is_load = 1'b0;
				is_job  = 1'b0;
			end
		endcase
	end

	assign len_sat     = (enc_in.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
	                                                           : enc_in.code_length;
	assign mask_w      = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
	assign code_masked = enc_in.code_bits & mask_w[CODE_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			code_mem[enc_in.symbol] <= code_masked;
			len_mem[enc_in.symbol]  <= len_sat;
		end
		if (accept && is_job) begin
			code_s1 <= code_mem[enc_in.symbol];
			len_s1  <= len_mem[enc_in.symbol];
			vld_s1  <= len_vld_q[enc_in.symbol];
			fin_s1  <= (func_t'(enc_in.func) == FUNC_FINISH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept && is_load)
				len_vld_q[enc_in.symbol] <= 1'b1;
			valid_s1 <= accept && is_job;
		end
	end

	// drop encodes of symbols without a code
	assign len_eff       = vld_s1 ? len_s1 : '0;
	assign push          = valid_s1 && (fin_s1 || (len_eff != '0));
	assign push_job.fin  = fin_s1;
	assign push_job.len  = len_eff;
	assign push_job.code = code_s1 << (LEN_W'(CODE_W) - len_eff);

endmodule

/* src/pce_queue.sv */
// Short job queue between the front end and the bit packer.
// Depends on pce_pkg.
module pce_queue
	import pce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  job_t               push_job,
	input  logic               pop,
	output logic               head_valid,
	output job_t               head_job,
	output logic [Q_CNT_W-1:0] cnt
);

	job_t                 slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign cnt        = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			cnt_q <= cnt_q + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
		end
	end

endmodule

/* src/pce_back.sv */
// Back end: bit packer that turns queued jobs into output bytes and trailers.
// Depends on pce_pkg and pce_if; takes jobs from pce_queue.
module pce_back
	import pce_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  job_t   head_job,
	output logic   pop,
	pce_out_if.source enc_out
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ENC  = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_TRL  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [BYTE_W-1:0]   pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WORD_W-1:0]   word_q;
	logic [REM_W-1:0]    rem_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_last_q;
	logic                out_eom_q;

	logic                slot_free;
	logic [WORD_W-1:0]   word_new;
	logic [REM_W-1:0]    total;
	logic [REM_W-1:0]    rem_next;
	logic                emit;

	assign slot_free = !out_valid_q || enc_out.ready;
	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign word_new  = {pend_q, {CODE_W{1'b0}}} | ({head_job.code, {BYTE_W{1'b0}}} >> cnt_q);
	assign total     = REM_W'(cnt_q) + head_job.len;
	assign rem_next  = rem_q - REM_W'(BYTE_W);
	assign emit      = slot_free && (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free)
				out_valid_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head_job.fin)
							state_q <= (cnt_q != '0) ? ST_PAD : ST_TRL;
						else if (total < REM_W'(BYTE_W)) begin
							pend_q <= word_new[WORD_W-1 -: BYTE_W];
							cnt_q  <= total[CNT_W-1:0];
						end else
							state_q <= ST_ENC;
					end
				end
				ST_ENC: begin
					if (slot_free && (rem_next < REM_W'(BYTE_W))) begin
						pend_q  <= word_q[WORD_W-BYTE_W-1 -: BYTE_W];
						cnt_q   <= rem_next[CNT_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (slot_free)
						state_q <= ST_TRL;
				end
				ST_TRL: begin
					if (slot_free) begin
						pend_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= word_new;
			rem_q  <= total;
		end else if (emit && (state_q == ST_ENC)) begin
			word_q <= word_q << BYTE_W;
			rem_q  <= rem_next;
		end
		if (emit) begin
			unique case (state_q)
				ST_ENC: begin
					out_byte_q <= word_q[WORD_W-1 -: BYTE_W];
					out_last_q <= (rem_next < REM_W'(BYTE_W));
					out_eom_q  <= 1'b0;
				end
				ST_PAD: begin
					out_byte_q <= pend_q;
					out_last_q <= 1'b0;
					out_eom_q  <= 1'b0;
				end
				default: begin
					out_byte_q <= (cnt_q != '0) ? (BYTE_W'(BYTE_W) - BYTE_W'(cnt_q)) : '0;
					out_last_q <= 1'b1;
					out_eom_q  <= 1'b1;
				end
			endcase
		end
	end

	assign enc_out.valid          = out_valid_q;
	assign enc_out.out_byte       = out_byte_q;
	assign enc_out.last_of_run    = out_last_q;
	assign enc_out.end_of_message = out_eom_q;

endmodule

/* src/prefix_code_byte_encoder_unit.sv */
// An encode item passes the front-end lookup register, a queue slot and the
// packer's registers before its first byte shows. Loads never reach the
// packer. Throughput: one item per cycle into a 4-entry job queue while it
// has room; the bit packer takes a job only once the last one's bytes (up
// to 4 per encode) are out. Reset clears the packer, the queue and the
// per-symbol length valid bits at once; there is no clearing pass.
module prefix_code_byte_encoder_unit
	import pce_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pce_in_if.sink    enc_in,
	pce_out_if.source enc_out
);

	logic               push;
	job_t               push_job;
	logic               pop;
	logic               head_valid;
	job_t               head_job;
	logic [Q_CNT_W-1:0] q_cnt;

	pce_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enc_in   (enc_in),
		.q_cnt    (q_cnt),
		.push     (push),
		.push_job (push_job)
	);

	pce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.cnt        (q_cnt)
	);

	pce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.enc_out    (enc_out)
	);

endmodule

/* src/pce_chk.sv */
// Port-level checks of the prefix-code byte encoder, bound to the top level.
// Depends on pce_pkg.
module pce_chk
	import pce_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_last,
	input logic              out_eom
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(out_last) && $stable(out_eom))
		else $error("result changed while stalled");

	a_eom_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eom |-> out_last)
		else $error("trailer not marked last");

	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eom |-> out_byte < BYTE_W'(BYTE_W))
		else $error("trailer pad count out of range");

endmodule

bind prefix_code_byte_encoder_unit pce_chk u_pce_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (enc_out.valid),
	.out_ready (enc_out.ready),
	.out_byte  (enc_out.out_byte),
	.out_last  (enc_out.last_of_run),
	.out_eom   (enc_out.end_of_message)
);

/* sim/pce_checker.sv */
// Checker for the prefix-code byte encoder: watches both channels, predicts every result
// item from the accepted input items and compares them in order. Depends on pce_pkg and pce_if.
module pce_checker
	import pce_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pce_in_if    in_ch,
	pce_out_if   out_ch,
	output int   mismatches,
	output int   waiting,
	output int   bytes_seen,
	output int   msgs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              eom;
	} byte_item_t;

	logic [CODE_W-1:0] code_tbl [TABLE_SIZE];
	logic [LEN_W-1:0]  len_tbl  [TABLE_SIZE];
	logic [6:0]        held_bits;
	logic [CNT_W-1:0]  held_cnt;
	byte_item_t        byte_q [$];
	int                n_bad, n_bytes, n_msgs;

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] len;
		logic [63:0]      acc;
		int               total;
		int               pad;
		byte_item_t       got, want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) len_tbl[i] = '0;
			held_bits = '0;
			held_cnt = '0;
			byte_q.delete();
			n_bad = 0;
			n_bytes = 0;
			n_msgs = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_message};
				n_bytes++;
				if (got.eom) n_msgs++;
				if (byte_q.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: unexpected result byte %02h last %0b eom %0b",
							$realtime, got.data, got.last, got.eom);
					n_bad++;
				end else begin
					want = byte_q.pop_front();
					if (got !== want) begin
						if (n_bad < 10)
							$display("%0t: expected byte %02h last %0b eom %0b, got byte %02h last %0b eom %0b",
								$realtime, want.data, want.last, want.eom,
								got.data, got.last, got.eom);
						n_bad++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				sym = in_ch.symbol;
				case (in_ch.func)
					FUNC_LOAD: begin
						len = (in_ch.code_length > LEN_CAP) ? LEN_W'(LEN_CAP) : in_ch.code_length;
						code_tbl[sym] = CODE_W'({32'd0, in_ch.code_bits} & ((64'd1 << len) - 64'd1));
						len_tbl[sym] = len;
					end
					FUNC_ENCODE: begin
						len = len_tbl[sym];
						if (len != 0) begin
							acc = (64'(held_bits) << len) | 64'(code_tbl[sym]);
							total = held_cnt + len;
							while (total >= BYTE_W) begin
								total -= BYTE_W;
								byte_q.push_back('{acc[total +: BYTE_W], total < BYTE_W, 1'b0});
							end
							held_cnt = CNT_W'(total);
							held_bits = acc[6:0] & 7'((1 << total) - 1);
						end
					end
					FUNC_FINISH: begin
						pad = 0;
						if (held_cnt != 0) begin
							pad = BYTE_W - held_cnt;
							acc = 64'(held_bits) << pad;
							byte_q.push_back('{acc[BYTE_W-1:0], 1'b0, 1'b0});
						end
						byte_q.push_back('{BYTE_W'(pad), 1'b1, 1'b1});
						held_bits = '0;
						held_cnt = '0;
					end
					default: ;
				endcase
			end
		end
		mismatches <= n_bad;
		waiting <= byte_q.size();
		bytes_seen <= n_bytes;
		msgs_seen <= n_msgs;
	end

endmodule

/* sim/tb.sv */
// Top of the prefix-code byte encoder testbench: clock, reset, directed and random items,
// random stalls on both channels and the verdict. Depends on pce_pkg, pce_if and pce_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pce_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic steady;
	int   mismatches, waiting, bytes_seen, msgs_seen;
	int   n_load, n_enc, n_fin, n_junk;
	bit   has_code [TABLE_SIZE];
	logic [SYM_W-1:0] live [$];

	pce_in_if  enc_in();
	pce_out_if enc_out();

	prefix_code_byte_encoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.enc_in  (enc_in),
		.enc_out (enc_out)
	);

	pce_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (enc_in),
		.out_ch     (enc_out),
		.mismatches (mismatches),
		.waiting    (waiting),
		.bytes_seen (bytes_seen),
		.msgs_seen  (msgs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		enc_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			enc_out.ready <= steady || ($urandom_range(99) >= 29);
		end
	end

	task automatic put_item(input logic [1:0] f, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		while (!steady && $urandom_range(99) < 29) begin
			enc_in.valid <= 1'b0;
			@(posedge clk);
		end
		enc_in.valid <= 1'b1;
		enc_in.func <= f;
		enc_in.symbol <= sym;
		enc_in.code_bits <= code;
		enc_in.code_length <= len;
		@(posedge clk);
		while (!enc_in.ready) @(posedge clk);
		case (f)
			FUNC_LOAD: begin
				n_load++;
				if (len != 0 && !has_code[sym]) live.push_back(sym);
				has_code[sym] = (len != 0);
			end
			FUNC_ENCODE: n_enc++;
			FUNC_FINISH: n_fin++;
			default: n_junk++;
		endcase
	endtask

	task automatic load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		put_item(FUNC_LOAD, sym, code, len);
	endtask

	task automatic encode(input logic [SYM_W-1:0] sym);
		put_item(FUNC_ENCODE, sym, $urandom, LEN_W'($urandom_range(63)));
	endtask

	task automatic finish_msg();
		put_item(FUNC_FINISH, SYM_W'($urandom), $urandom, LEN_W'($urandom_range(63)));
	endtask

	// hold off the sender until every predicted byte has come out
	task automatic drain();
		enc_in.valid <= 1'b0;
		@(posedge clk);
		for (int g = 0; g < 5000 && waiting != 0; g++) @(posedge clk);
	endtask

	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 70) return LEN_W'($urandom_range(1, 10));
		if (r < 90) return LEN_W'($urandom_range(11, 32));
		return LEN_W'($urandom_range(33, 63));
	endfunction

	function automatic logic [SYM_W-1:0] pick_sym();
		if (live.size() > 0 && $urandom_range(9) < 8)
			return live[$urandom_range(live.size() - 1)];
		return SYM_W'($urandom_range(255));
	endfunction

	initial begin
		int base;
		int r;
		enc_in.valid <= 1'b0;
		enc_in.func <= FUNC_LOAD;
		enc_in.symbol <= '0;
		enc_in.code_bits <= '0;
		enc_in.code_length <= '0;
		steady <= 1'b0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		finish_msg();
		encode(8'h00);
		put_item(FUNC_UNUSED, 8'hFF, '1, '1);
		load(8'h00, 32'hFFFF_FFFF, 6'd32);
		load(8'hFF, 32'h0000_0000, 6'd1);
		load(8'hA5, 32'h1234_5678, 6'd63);
		load(8'h01, 32'hFFFF_FFFF, 6'd3);
		load(8'h02, 32'hDEAD_BEEF, 6'd0);
		load(8'h03, 32'h0000_0055, 6'd7);
		encode(8'h00);
		finish_msg();
		encode(8'hFF);
		encode(8'h01);
		encode(8'h02);
		encode(8'h03);
		finish_msg();
		encode(8'hA5);
		encode(8'hFF);
		encode(8'hA5);
		finish_msg();
		load(8'h03, 32'h0000_0000, 6'd0);
		encode(8'h03);
		finish_msg();

		base = n_load + n_enc + n_fin;
		for (int m = 0; n_load + n_enc + n_fin - base < 120; m++) begin
			steady <= (m >= 6 && m < 10);
			if (m == 0 || $urandom_range(99) < 30)
				repeat ($urandom_range(1, 6)) load(SYM_W'($urandom), $urandom, pick_len());
			repeat ($urandom_range(2, 10)) begin
				r = $urandom_range(99);
				if (r < 5)
					put_item(FUNC_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
				else if (r < 12)
					load(SYM_W'($urandom), $urandom, pick_len());
				else
					encode(pick_sym());
			end
			if ($urandom_range(99) < 85) finish_msg();
			if (m == 3) drain();
		end
		steady <= 1'b0;
		finish_msg();
		drain();
		repeat (32) @(posedge clk);

		$display("sent %0d loads, %0d encodes, %0d finishes, %0d unused-function items",
			n_load, n_enc, n_fin, n_junk);
		$display("checked %0d output bytes, %0d of them message trailers", bytes_seen, msgs_seen);
		if (mismatches == 0 && waiting == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
